FILE: rtl/sa_pkg.sv
// Package for the stack ALU: opcodes, status codes, sizes and shared types.
// No dependencies.
`timescale 1ns / 1ps
package sa_pkg;
  localparam int unsigned StackDepth = 64;
  localparam int unsigned AddrW      = $clog2(StackDepth);
  localparam int unsigned CountW     = $clog2(StackDepth + 1);
  localparam int unsigned DepthW     = 7;
  localparam int unsigned WordW      = 32;

  localparam logic [2:0] OpPush = 3'd0;
  localparam logic [2:0] OpAdd  = 3'd1;
  localparam logic [2:0] OpSub  = 3'd2;
  localparam logic [2:0] OpDiv  = 3'd3;
  localparam logic [2:0] OpMul  = 3'd4;
  localparam logic [2:0] OpMod  = 3'd5;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StShort   = 2'd1;
  localparam logic [1:0] StDivZero = 2'd2;
  localparam logic [1:0] StFull    = 2'd3;

  // Divider request: magnitudes plus result sign handling
  typedef struct packed {
    logic             start;
    logic [WordW-1:0] dividend;
    logic [WordW-1:0] divisor;
    logic             neg_q;
    logic             neg_r;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [WordW-1:0] quot;
    logic [WordW-1:0] rem;
  } div_rsp_t;
endpackage

FILE: rtl/sa_divider.sv
// Radix-2 restoring divider for 32-bit magnitudes, one quotient bit a cycle.
// Depends on sa_pkg.
`timescale 1ns / 1ps
module sa_divider (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sa_pkg::div_req_t req_i,
  output sa_pkg::div_rsp_t rsp_o
);
  localparam int unsigned W = sa_pkg::WordW;

  logic [W-1:0] quot_q, quot_d, rem_q, rem_d, dvs_q, dvs_d;
  logic [5:0]   cnt_q, cnt_d;
  logic         busy_q, busy_d, done_q, done_d, nq_q, nq_d, nr_q, nr_d;
  logic [W:0]   trial;
  logic [W:0]   diff;

  // One shift-subtract step per cycle
  always_comb begin
    quot_d = quot_q; rem_d = rem_q; dvs_d = dvs_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0; nq_d = nq_q; nr_d = nr_q;
    trial = {rem_q, quot_q[W-1]};
    diff  = trial - {1'b0, dvs_q};
    if (req_i.start) begin
      quot_d = req_i.dividend; rem_d = '0; dvs_d = req_i.divisor;
      cnt_d = 6'(W); busy_d = 1'b1; nq_d = req_i.neg_q; nr_d = req_i.neg_r;
    end else if (busy_q) begin
      if (!diff[W]) begin
        rem_d = diff[W-1:0];
        quot_d = {quot_q[W-2:0], 1'b1};
      end else begin
        rem_d = trial[W-1:0];
        quot_d = {quot_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d; rem_q <= rem_d; dvs_q <= dvs_d; nq_q <= nq_d; nr_q <= nr_d;
  end

  // Apply signs after the last step
  assign rsp_o.done = done_q;
  assign rsp_o.quot = nq_q ? (W'(0) - quot_q) : quot_q;
  assign rsp_o.rem  = nr_q ? (W'(0) - rem_q) : rem_q;
endmodule

FILE: rtl/stack_alu_arithmetic.sv
// Top level of the stack ALU: stack memory, control sequencer, result ports.
// Depends on sa_pkg and sa_divider.
`timescale 1ns / 1ps
//
//  channel  | ports                             | transfer
//  ---------+-----------------------------------+------------------------
//  command  | opcode_i, push_value_i            | start_i && !busy_o
//  result   | status_o, top_value_o, depth_o    | result_valid_o (1 cycle)
//
// Steps from the accepting edge to the result strobe: push strobes from
// S_RDT; too short, stack full or unused opcode pass S_RDT, S_TOP; division
// by zero S_RDT, S_RDB, S_EXEC. add/sub/mul: S_RDT, S_RDB, S_EXEC, S_WB (two
// memory reads, operand capture, op and writeback). div/mod wait in S_DIV
// for the divider before S_WB. busy_o drops in the strobe cycle. Reset
// clears the count and the sequencer; the stack memory is not cleared. The
// receiver cannot stall; each result is shown for one cycle only.
module stack_alu_arithmetic (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  opcode_i,
  input  logic signed [31:0] push_value_i,
  output logic        result_valid_o,
  output logic [1:0]  status_o,
  output logic signed [31:0] top_value_o,
  output logic [6:0]  depth_o
);
  localparam int unsigned AW = sa_pkg::AddrW;
  localparam int unsigned CW = sa_pkg::CountW;
  localparam int unsigned W  = sa_pkg::WordW;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RDT   = 7'b0000010,
    S_RDB   = 7'b0000100,
    S_EXEC  = 7'b0001000,
    S_DIV   = 7'b0010000,
    S_WB    = 7'b0100000,
    S_TOP   = 7'b1000000
  } state_e;

  state_e       state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [2:0]   op_q;
  logic [W-1:0] val_q, t_q, b_q, res_q, res_d;
  logic         op_ld;

  // Stack memory, one write and one registered read port
  logic [W-1:0] mem [sa_pkg::StackDepth];
  logic         we;
  logic [AW-1:0] waddr, raddr;
  logic [W-1:0] wdata, rdata_q;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  // Output registers
  logic         rv_q, rv_d;
  logic [1:0]   st_q, st_d;
  logic [W-1:0] top_q, top_d;

  sa_pkg::div_req_t dreq;
  sa_pkg::div_rsp_t drsp;
  sa_divider u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  logic is_arith, is_div;
  assign is_arith = (op_q != sa_pkg::OpPush) && (op_q <= sa_pkg::OpMod);
  assign is_div   = (op_q == sa_pkg::OpDiv) || (op_q == sa_pkg::OpMod);

  logic [63:0] prod;
  assign prod = 64'(t_q) * 64'(b_q);

  // Sequencer
  always_comb begin
    state_d = state_q; cnt_d = cnt_q; rv_d = 1'b0; st_d = st_q; top_d = top_q;
    res_d = res_q; we = 1'b0; waddr = '0; wdata = val_q; raddr = '0;
    op_ld = 1'b0; dreq = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_ld = 1'b1;
          state_d = S_RDT;
        end
      end
      S_RDT: begin
        // decide the item and issue the first read
        raddr = AW'(cnt_q - CW'(1));
        if (op_q == sa_pkg::OpPush) begin
          if (cnt_q >= CW'(sa_pkg::StackDepth)) begin
            st_d = sa_pkg::StFull;
            state_d = S_TOP;
          end else begin
            we = 1'b1; waddr = AW'(cnt_q); wdata = val_q;
            cnt_d = cnt_q + CW'(1);
            st_d = sa_pkg::StOk;
            top_d = val_q; rv_d = 1'b1; state_d = S_IDLE;
          end
        end else if (is_arith && cnt_q < CW'(2)) begin
          st_d = sa_pkg::StShort; state_d = S_TOP;
        end else if (!is_arith) begin
          st_d = sa_pkg::StOk; state_d = S_TOP;
        end else begin
          state_d = S_RDB;
        end
      end
      S_RDB: begin
        raddr = AW'(cnt_q - CW'(2));
        state_d = S_EXEC;
      end
      S_EXEC: begin
        // t_q holds the top now, rdata_q the element below
        if (is_div && t_q == '0) begin
          st_d = sa_pkg::StDivZero; top_d = t_q; rv_d = 1'b1; state_d = S_IDLE;
        end else if (is_div) begin
          dreq.start = 1'b1;
          dreq.dividend = rdata_q[W-1] ? (W'(0) - rdata_q) : rdata_q;
          dreq.divisor  = t_q[W-1] ? (W'(0) - t_q) : t_q;
          dreq.neg_q = rdata_q[W-1] ^ t_q[W-1];
          dreq.neg_r = rdata_q[W-1];
          state_d = S_DIV;
        end else begin
          state_d = S_WB;
        end
      end
      S_DIV: begin
        if (drsp.done) begin
          res_d = (op_q == sa_pkg::OpDiv) ? drsp.quot : drsp.rem;
          state_d = S_WB;
        end
      end
      S_WB: begin
        if (!is_div) begin
          unique case (op_q)
            sa_pkg::OpAdd: res_d = b_q + t_q;
            sa_pkg::OpSub: res_d = b_q - t_q;
            default:       res_d = prod[W-1:0];
          endcase
        end
        we = 1'b1; waddr = AW'(cnt_q - CW'(2)); wdata = res_d;
        cnt_d = cnt_q - CW'(1);
        st_d = sa_pkg::StOk; top_d = res_d; rv_d = 1'b1; state_d = S_IDLE;
      end
      S_TOP: begin
        // unchanged stack: rdata_q has the top from the read in S_RDT
        top_d = (cnt_q == '0) ? '0 : rdata_q;
        rv_d = 1'b1; state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; cnt_q <= '0; rv_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; rv_q <= rv_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (op_ld) begin
      op_q <= opcode_i; val_q <= push_value_i;
    end
    if (state_q == S_RDB) t_q <= rdata_q;
    if (state_q == S_EXEC) b_q <= rdata_q;
    res_q <= res_d; st_q <= st_d; top_q <= top_d;
  end

  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = rv_q;
  assign status_o       = st_q;
  assign top_value_o    = top_q;
  assign depth_o        = 7'(cnt_q);
endmodule
